// File: design/mi3_pkg.sv
// shared constants for the 3x3 matrix inverse block
package mi3_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ENT = 9;
endpackage

// File: design/mi3_lane.sv
// one division lane: pipelined restoring divider with sign fix and saturation
module mi3_lane import mi3_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int COF_BITS  = 2 * WORD_BITS + 1,
  parameter int DET_BITS  = 3 * WORD_BITS + 2
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [COF_BITS-1:0]  cof,
  input  logic signed [DET_BITS-1:0]  det,
  output logic signed [WORD_BITS-1:0] quo
);
  // numerator magnitude shifted left by 2*frac; quotient bits: all NUM_BITS (sat detect)
  localparam int NUM_BITS = COF_BITS + 2 * FRAC_BITS;
  localparam int QB = NUM_BITS;
  localparam int RB = DET_BITS + 1;

  logic [NUM_BITS-1:0] num_r [QB+1];
  logic [RB-1:0]       rem_r [QB+1];
  logic [RB-1:0]       den_r [QB+1];
  logic                neg_r [QB+1];
  logic [QB-1:0]       q_r   [QB+1];
  logic [COF_BITS-1:0] cmag;
  logic [DET_BITS-1:0] dmag;

  always_comb begin
    cmag = cof[COF_BITS-1] ? COF_BITS'(-cof) : COF_BITS'(cof);
    dmag = det[DET_BITS-1] ? DET_BITS'(-det) : DET_BITS'(det);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r[0] <= NUM_BITS'(cmag) << (2 * FRAC_BITS);
      rem_r[0] <= '0;
      den_r[0] <= RB'(dmag);
      neg_r[0] <= cof[COF_BITS-1] ^ det[DET_BITS-1];
      q_r[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RB-1:0] sh;
    logic          ge;
    always_comb begin
      sh = {rem_r[s][RB-2:0], num_r[s][NUM_BITS-1]};
      ge = sh >= den_r[s];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[s+1] <= num_r[s] << 1;
        rem_r[s+1] <= ge ? sh - den_r[s] : sh;
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        q_r[s+1]   <= {q_r[s][QB-2:0], ge};
      end
    end
  end

  logic [QB-1:0] q;
  logic          big;
  always_comb begin
    q   = q_r[QB];
    big = (q >> (WORD_BITS - 1)) != '0;
    if (neg_r[QB]) begin
      if (big) quo = {1'b1, {(WORD_BITS-1){1'b0}}};
      else     quo = -$signed(WORD_BITS'(q));
    end else begin
      if (big) quo = {1'b0, {(WORD_BITS-1){1'b1}}};
      else     quo = $signed(WORD_BITS'(q));
    end
  end
endmodule

// File: design/matrix3_inverse.sv
// top level: 3x3 fixed-point matrix inverse by adjugate over parallel divider lanes
//
// usage
//   one beat on the in_ channel carries the nine entries m00..m22 in signed
//   Q(WORD_BITS-FRAC_BITS).FRAC_BITS; one beat on the out_ channel returns the
//   nine inverse entries inv00..inv22 and a singular flag
//   nine divider lanes work side by side, one per cofactor; a merging stage
//   zeroes the entries and raises singular when the determinant is zero
//   throughput: one beat per cycle, back to back, while out_stall does not hold the pipeline
//   the pipeline depth is set by the bit-per-stage divider, plus the product,
//   cofactor, determinant, lane input and output stages
//   the whole pipeline advances only when the output register is empty or
//   being taken, so a stall on out_stall freezes every stage and in_stall
//   follows it; no beat is lost or repeated
//   reset clears the valid bits of every stage; payload registers are not reset
module matrix3_inverse import mi3_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [WORD_BITS-1:0] in_m00, in_m01, in_m02,
  input  logic signed [WORD_BITS-1:0] in_m10, in_m11, in_m12,
  input  logic signed [WORD_BITS-1:0] in_m20, in_m21, in_m22,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [WORD_BITS-1:0] out_inv00, out_inv01, out_inv02,
  output logic signed [WORD_BITS-1:0] out_inv10, out_inv11, out_inv12,
  output logic signed [WORD_BITS-1:0] out_inv20, out_inv21, out_inv22,
  output logic out_singular
);
  localparam int PB = 2 * WORD_BITS;
  localparam int CB = 2 * WORD_BITS + 1;
  localparam int DB = 3 * WORD_BITS + 2;
  // cofactor split point for the determinant products
  localparam int LO = WORD_BITS + 1;
  localparam int LB = 2 * WORD_BITS + 2;
  localparam int NUM_BITS = CB + 2 * FRAC_BITS;
  // stages: products, cofactors, det products, det sum, lane in, divider, output
  localparam int LAT = 5 + NUM_BITS + 1;

  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  logic signed [WORD_BITS-1:0] a [NUM_ENT];
  assign a = '{in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22};

  // stage 1: eighteen products plus held row 0
  logic signed [PB-1:0] pa_r [NUM_ENT], pb_r [NUM_ENT];
  logic signed [WORD_BITS-1:0] r0_r [3], r0b_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r[0] <= a[4]*a[8]; pb_r[0] <= a[7]*a[5];
      pa_r[1] <= a[2]*a[7]; pb_r[1] <= a[1]*a[8];
      pa_r[2] <= a[1]*a[5]; pb_r[2] <= a[2]*a[4];
      pa_r[3] <= a[5]*a[6]; pb_r[3] <= a[3]*a[8];
      pa_r[4] <= a[0]*a[8]; pb_r[4] <= a[2]*a[6];
      pa_r[5] <= a[3]*a[2]; pb_r[5] <= a[0]*a[5];
      pa_r[6] <= a[3]*a[7]; pb_r[6] <= a[6]*a[4];
      pa_r[7] <= a[6]*a[1]; pb_r[7] <= a[0]*a[7];
      pa_r[8] <= a[0]*a[4]; pb_r[8] <= a[3]*a[1];
      r0_r <= '{a[0], a[1], a[2]};
      r0b_r <= r0_r;
    end
  end

  // stage 2: cofactors
  logic signed [CB-1:0] cof_r [NUM_ENT], cof2_r [NUM_ENT], cof3_r [NUM_ENT];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_ENT; i++) cof_r[i] <= CB'(pa_r[i]) - CB'(pb_r[i]);
    end
  end

  // stage 3: determinant terms, row 0 word times high and low cofactor halves
  logic signed [PB-1:0] dh_r [3];
  logic signed [LB-1:0] dl_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dh_r[k] <= PB'(r0b_r[k]) * PB'($signed(cof_r[3*k][CB-1:LO]));
        dl_r[k] <= LB'(r0b_r[k]) * LB'($signed({1'b0, cof_r[3*k][LO-1:0]}));
      end
      cof2_r <= cof_r;
    end
  end

  // stage 4: determinant sum, high halves weighted by 2^LO
  logic signed [DB-1:0] det_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      det_r  <= ((DB'(dh_r[0]) + DB'(dh_r[1]) + DB'(dh_r[2])) <<< LO)
                + DB'(dl_r[0]) + DB'(dl_r[1]) + DB'(dl_r[2]);
      cof3_r <= cof2_r;
    end
  end

  // singular flag rides alongside the lanes
  logic sing_d_r [NUM_BITS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_d_r[0] <= det_r == '0;
      for (int i = 1; i <= NUM_BITS; i++) sing_d_r[i] <= sing_d_r[i-1];
    end
  end

  logic signed [WORD_BITS-1:0] q [NUM_ENT];
  for (genvar l = 0; l < NUM_ENT; l++) begin : g_lane
    mi3_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .COF_BITS(CB),
               .DET_BITS(DB)) u_lane (
      .clk(clk), .adv(adv), .cof(cof3_r[l]), .det(det_r), .quo(q[l]));
  end

  // merge: output register, zeroed when singular
  logic signed [WORD_BITS-1:0] inv_r [NUM_ENT];
  logic sing_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= sing_d_r[NUM_BITS];
      for (int i = 0; i < NUM_ENT; i++) inv_r[i] <= sing_d_r[NUM_BITS] ? '0 : q[i];
    end
  end

  assign out_inv00 = inv_r[0]; assign out_inv01 = inv_r[1]; assign out_inv02 = inv_r[2];
  assign out_inv10 = inv_r[3]; assign out_inv11 = inv_r[4]; assign out_inv12 = inv_r[5];
  assign out_inv20 = inv_r[6]; assign out_inv21 = inv_r[7]; assign out_inv22 = inv_r[8];
  assign out_singular = sing_r;
endmodule
